// ===== rtl/esgd_pkg.sv =====
package esgd_pkg;

	// Default sizes of the tables and of the sigmoid lookup.
	localparam int NODES_DEF       = 1024;
	localparam int DIM_DEF         = 128;
	localparam int SIG_ENTRIES_DEF = 1024;

	// Learning rate after reset, unsigned Q0.16.
	localparam logic [15:0] LR_RESET = 16'd1638;

	// 6.0 in the Q8.24 format of the dot product.
	localparam longint SIX_Q24 = 64'd100663296;

	// 1.0 in Q0.16, one bit above the output field.
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Division by three as a multiply and shift, exact for values below 2^17.
	localparam logic [16:0] DIV3_MUL   = 17'd87382;
	localparam int          DIV3_SHIFT = 18;

	// Cycles from a settled dot product to a settled gradient.
	localparam logic [2:0] SIG_WAIT = 3'd5;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_TRAIN  = 2'd2,
		KIND_COMMIT = 2'd3
	} kind_t;

	// Operations that run through the datapath pipeline.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLR,
		OP_WR,
		OP_RD,
		OP_DOT,
		OP_UPD,
		OP_COMMIT
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_DOT,
		ST_DOT_DRAIN,
		ST_SIG,
		ST_UPD,
		ST_COMMIT,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [9:0]         node;
		logic [9:0]         target;
		logic               label;
		logic [6:0]         dim_index;
		logic               table_select;
		logic signed [15:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] read_value;
		logic [15:0]        probability;
	} out_word_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  row_ok;
		logic  dim_ok;
		logic  busy;
	} dp_status_t;

	// Saturate a sum to a signed Q4.12 element.
	function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
		logic signed [15:0] r;
		if (v > 25'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -25'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Saturate a sum to a signed 24-bit accumulator entry.
	function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
		logic signed [23:0] r;
		if (v > 25'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -25'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// Unsigned quotient by shift and subtract, used only while building tables.
	// The divisor stays below 2^63, so the partial remainder never overflows.
	function automatic longint unsigned udiv(input longint unsigned n,
		input longint unsigned q);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= q) begin
				rem    = rem - q;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// One sigmoid table entry in Q0.16, evaluated at elaboration only.
	// exp(-|x|) comes from a truncated series at an eighth of |x|, squared three times.
	function automatic logic [16:0] sig_entry(input longint i, input longint entries);
		longint                r;
		longint unsigned       a;
		longint unsigned       den;
		longint unsigned       term;
		longint unsigned       e;
		longint unsigned       d;
		longint                sum;
		logic [16:0]           res;
		r    = 12 * i - 6 * entries;
		a    = longint'((r < 0) ? -r : r);
		den  = longint'(8 * entries);
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		for (int k = 1; k <= 24; k++) begin
			term = udiv(term * a, den * longint'(k));
			if (k[0] == 1'b1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		e = (sum < 0) ? 64'd0 : longint'(sum);
		for (int k = 0; k < 3; k++) begin
			e = (e * e) >> 30;
		end
		d = (64'd1 << 30) + e;
		if (r >= 0) begin
			res = 17'(udiv((64'd1 << 46) + (d >> 1), d));
		end else begin
			res = 17'(udiv((e << 16) + (d >> 1), d));
		end
		return res;
	endfunction

endpackage

// ===== rtl/esgd_dp.sv =====
module esgd_dp #(
	parameter int NODES       = esgd_pkg::NODES_DEF,
	parameter int DIM         = esgd_pkg::DIM_DEF,
	parameter int SIG_ENTRIES = esgd_pkg::SIG_ENTRIES_DEF,
	localparam int DW         = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  esgd_pkg::in_word_t    in_word,
	input  logic                  lr_we,
	input  logic [15:0]           lr_data,
	input  esgd_pkg::dp_cmd_t     cmd,
	input  logic [DW-1:0]         elem,
	output esgd_pkg::dp_status_t  status,
	output esgd_pkg::out_word_t   result
);
	import esgd_pkg::*;

	localparam int DEPTH = NODES * DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1;
	localparam int EW    = $clog2(SIG_ENTRIES + 1);
	localparam int ZW    = 33 + DW;
	localparam int PW    = 28 + EW;
	localparam int QW    = PW - 26;
	localparam int GW    = 35;
	localparam int MW    = GW + 16;

	localparam logic signed [ZW-1:0] SIX = ZW'(SIX_Q24);
	localparam logic [EW-1:0]        EV  = EW'(SIG_ENTRIES);
	localparam logic signed [MW-1:0] RND = MW'(64'd1 << 31);

	// Item, rate and pipeline state.
	in_word_t           item_q;
	logic [15:0]        lr_q;
	op_t                op_s1;
	op_t                op_s2;
	logic [DW-1:0]      d_s1;
	logic [DW-1:0]      d_s2;

	// Memories and their read registers.
	logic signed [15:0] node_mem [DEPTH];
	logic signed [15:0] ctx_mem [DEPTH];
	logic signed [23:0] acc_mem [DIM];
	logic signed [15:0] node_rd_s1;
	logic signed [15:0] ctx_rd_s1;
	logic signed [23:0] acc_rd_s1;

	// Multiply stage registers.
	logic signed [MW-1:0] mul_a_s2;
	logic signed [MW-1:0] mul_b_s2;
	logic signed [24:0]   sum_s2;
	logic signed [15:0]   ctx_s2;
	logic signed [23:0]   acc_s2;
	logic signed [15:0]   rd_q;

	// Dot product and sigmoid chain.
	logic signed [ZW-1:0] z_q;
	logic [PW-1:0]        prod_q;
	logic                 over_q1;
	logic                 under_q1;
	logic [IW-1:0]        idx_q;
	logic                 over_q2;
	logic                 under_q2;
	logic [16:0]          rom_q;
	logic                 over_q3;
	logic                 under_q3;
	logic [16:0]          p_q;
	logic signed [GW-1:0] g_q;
	out_word_t            res_q;

	logic [16:0]          rom_tab [SIG_ENTRIES];

	logic                 node_ok;
	logic                 target_ok;
	logic                 host_op;
	logic [31:0]          dim_ext;
	logic [DW-1:0]        dsel;
	logic [31:0]          nbase;
	logic [31:0]          cbase;
	logic [31:0]          tbase;
	logic [AW-1:0]        naddr0;
	logic [AW-1:0]        caddr0;
	logic [AW-1:0]        naddr2;
	logic [AW-1:0]        caddr2;
	logic signed [MW-1:0] ra;
	logic signed [MW-1:0] rb;
	logic signed [18:0]   da;
	logic signed [18:0]   dc;
	logic signed [23:0]   acc_new;
	logic signed [15:0]   ctx_new;
	logic signed [15:0]   node_new;
	logic signed [ZW-1:0] w;
	logic [QW+16:0]       qmul;
	logic [QW-2:0]        idx_full;
	logic signed [17:0]   diff;
	logic [15:0]          prob_sat;

	// Sigmoid lookup table, built from constants.
	for (genvar i = 0; i < SIG_ENTRIES; i++) begin : g_rom
		localparam logic [16:0] ENT = sig_entry(longint'(i), longint'(SIG_ENTRIES));
		assign rom_tab[i] = ENT;
	end

	// Range checks and status for the controller.
	always_comb begin
		node_ok       = 32'(item_q.node) < 32'(NODES);
		target_ok     = 32'(item_q.target) < 32'(NODES);
		status.kind   = item_q.kind;
		status.row_ok = (item_q.kind == KIND_TRAIN) ? (node_ok && target_ok) : node_ok;
		status.dim_ok = 32'(item_q.dim_index) < 32'(DIM);
		status.busy   = (op_s1 != OP_NONE) || (op_s2 != OP_NONE);
	end

	// Addresses for the read stage and the write-back stage.
	always_comb begin
		host_op = (cmd.op == OP_RD) || (cmd.op == OP_WR);
		dim_ext = 32'(item_q.dim_index);
		dsel    = host_op ? dim_ext[DW-1:0] : elem;
		nbase   = 32'(item_q.node) * 32'(DIM);
		tbase   = 32'(item_q.target) * 32'(DIM);
		cbase   = host_op ? nbase : tbase;
		naddr0  = AW'(nbase + 32'(dsel));
		caddr0  = AW'(cbase + 32'(dsel));
		naddr2  = AW'(nbase + 32'(d_s2));
		caddr2  = AW'(tbase + 32'(d_s2));
	end

	// Rounded update terms and saturated new values.
	always_comb begin
		ra       = mul_a_s2 + RND;
		rb       = mul_b_s2 + RND;
		da       = ra[50:32];
		dc       = rb[50:32];
		acc_new  = sat24(25'(acc_s2) + 25'(da));
		ctx_new  = sat16(25'(ctx_s2) + 25'(dc));
		node_new = sat16(sum_s2);
	end

	// Item and learning rate registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
		end else if (lr_we) begin
			lr_q <= lr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_word;
		end
	end

	// Operation tags down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			op_s2 <= OP_NONE;
		end else begin
			op_s1 <= cmd.op;
			op_s2 <= op_s1;
		end
	end

	// Node table: host writes at issue, commit writes at write-back.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WR && !item_q.table_select) begin
			node_mem[naddr0] <= item_q.value;
		end else if (op_s2 == OP_COMMIT) begin
			node_mem[naddr2] <= node_new;
		end
		node_rd_s1 <= node_mem[naddr0];
	end

	// Context table: host writes at issue, training updates at write-back.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WR && item_q.table_select) begin
			ctx_mem[caddr0] <= item_q.value;
		end else if (op_s2 == OP_UPD) begin
			ctx_mem[caddr2] <= ctx_new;
		end
		ctx_rd_s1 <= ctx_mem[caddr0];
	end

	// Update accumulator, swept to zero after reset and on commit.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLR) begin
			acc_mem[elem] <= '0;
		end else if (op_s2 == OP_UPD) begin
			acc_mem[d_s2] <= acc_new;
		end else if (op_s2 == OP_COMMIT) begin
			acc_mem[d_s2] <= '0;
		end
		acc_rd_s1 <= acc_mem[dsel];
	end

	// Multiply stage: shared between dot product and update passes.
	always_ff @(posedge clk) begin
		d_s1 <= dsel;
		d_s2 <= d_s1;
		if (op_s1 == OP_DOT) begin
			mul_a_s2 <= node_rd_s1 * ctx_rd_s1;
		end else begin
			mul_a_s2 <= g_q * ctx_rd_s1;
		end
		mul_b_s2 <= g_q * node_rd_s1;
		sum_s2   <= 25'(node_rd_s1) + 25'(acc_rd_s1);
		ctx_s2   <= ctx_rd_s1;
		acc_s2   <= acc_rd_s1;
		if (op_s1 == OP_RD) begin
			rd_q <= item_q.table_select ? ctx_rd_s1 : node_rd_s1;
		end
	end

	// Dot product accumulation.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			z_q <= '0;
		end else if (op_s2 == OP_DOT) begin
			z_q <= z_q + ZW'(mul_a_s2);
		end
	end

	// Table index: floor((z + 6) * entries / 12) by shift and reciprocal.
	always_comb begin
		w        = z_q + SIX;
		qmul     = prod_q[PW-1:26] * DIV3_MUL;
		idx_full = qmul[QW+16:DIV3_SHIFT];
		diff     = (item_q.label ? 18'sh10000 : 18'sh0) - $signed({1'b0, p_q});
		prob_sat = p_q[16] ? 16'hFFFF : p_q[15:0];
	end

	// Sigmoid and gradient chain, one step per cycle.
	always_ff @(posedge clk) begin
		prod_q   <= w[27:0] * EV;
		over_q1  <= z_q > SIX;
		under_q1 <= z_q < -SIX;
		if (32'(idx_full) >= 32'(SIG_ENTRIES)) begin
			idx_q <= IW'(SIG_ENTRIES - 1);
		end else begin
			idx_q <= IW'(idx_full);
		end
		over_q2  <= over_q1;
		under_q2 <= under_q1;
		rom_q    <= rom_tab[idx_q];
		over_q3  <= over_q2;
		under_q3 <= under_q2;
		if (over_q3) begin
			p_q <= ONE_Q16;
		end else if (under_q3) begin
			p_q <= '0;
		end else begin
			p_q <= rom_q;
		end
		g_q <= $signed({1'b0, lr_q}) * diff;
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.read_value  <= (item_q.kind == KIND_READ && status.row_ok && status.dim_ok)
				? rd_q : '0;
			res_q.probability <= (item_q.kind == KIND_TRAIN && status.row_ok) ? prob_sat : '0;
		end
	end

	assign result = res_q;

endmodule

// ===== rtl/esgd_ctrl.sv =====
module esgd_ctrl #(
	parameter int DIM = esgd_pkg::DIM_DEF,
	localparam int DW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  esgd_pkg::dp_status_t  status,
	output esgd_pkg::dp_cmd_t     cmd,
	output logic [DW-1:0]         elem
);
	import esgd_pkg::*;

	state_t        state_q;
	state_t        state_d;
	logic [DW-1:0] d_q;
	logic [DW-1:0] d_d;
	logic [2:0]    wait_q;
	logic [2:0]    wait_d;
	logic          out_valid_q;
	logic          last;

	// State, element counter and output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			d_q         <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			d_q     <= d_d;
			wait_q  <= wait_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		last         = d_q == DW'(DIM - 1);
		state_d      = state_q;
		d_d          = d_q;
		wait_d       = wait_q;
		cmd.op       = OP_NONE;
		cmd.load     = 1'b0;
		cmd.res_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLR;
				if (last) begin
					d_d     = '0;
					state_d = ST_IDLE;
				end else begin
					d_d = d_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_FINISH;
				case (status.kind)
					KIND_WRITE: begin
						if (status.row_ok && status.dim_ok) begin
							cmd.op = OP_WR;
						end
					end
					KIND_READ: begin
						if (status.row_ok && status.dim_ok) begin
							cmd.op  = OP_RD;
							state_d = ST_DRAIN;
						end
					end
					KIND_TRAIN: begin
						if (status.row_ok) begin
							state_d = ST_DOT;
						end
					end
					KIND_COMMIT: begin
						if (status.row_ok) begin
							state_d = ST_COMMIT;
						end
					end
					default: state_d = ST_FINISH;
				endcase
			end
			ST_DOT: begin
				cmd.op = OP_DOT;
				if (last) begin
					d_d     = '0;
					state_d = ST_DOT_DRAIN;
				end else begin
					d_d = d_q + 1'b1;
				end
			end
			ST_DOT_DRAIN: begin
				if (!status.busy) begin
					wait_d  = '0;
					state_d = ST_SIG;
				end
			end
			ST_SIG: begin
				if (wait_q == SIG_WAIT - 3'd1) begin
					state_d = ST_UPD;
				end else begin
					wait_d = wait_q + 3'd1;
				end
			end
			ST_UPD: begin
				cmd.op = OP_UPD;
				if (last) begin
					d_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					d_d = d_q + 1'b1;
				end
			end
			ST_COMMIT: begin
				cmd.op = OP_COMMIT;
				if (last) begin
					d_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					d_d = d_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!status.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !result_stall) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = out_valid_q;
	assign elem         = d_q;

endmodule

// ===== rtl/embedding_sgd_negative_sampling.sv =====
// Channel   Direction  Handshake                 Word
// item      in         item_valid / item_stall   esgd_pkg::in_word_t
// result    out        result_valid / result_stall esgd_pkg::out_word_t
// lr        in         lr_we (no handshake back)  lr_data, learning rate Q0.16
//
// After acceptance a train word runs a pass for the dot product, a drain, the
// sigmoid and gradient steps, a pass for the updates, a second drain and the
// loading of the result. A commit word runs a pass and a drain, a read word a
// drain, and a write word goes straight to its result. The next item is taken
// only after the result is loaded. After reset the accumulator is swept to zero
// element by element as items wait. A stalled result holds back the next one.
module embedding_sgd_negative_sampling #(
	parameter int NODES       = esgd_pkg::NODES_DEF,
	parameter int DIM         = esgd_pkg::DIM_DEF,
	parameter int SIG_ENTRIES = esgd_pkg::SIG_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  esgd_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output esgd_pkg::out_word_t result,
	input  logic                lr_we,
	input  logic [15:0]         lr_data
);
	import esgd_pkg::*;

	localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;

	dp_cmd_t       cmd;
	dp_status_t    status;
	logic [DW-1:0] elem;

	// Sequencer.
	esgd_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd),
		.elem         (elem)
	);

	// Tables, multiply pipeline and sigmoid.
	esgd_dp #(
		.NODES       (NODES),
		.DIM         (DIM),
		.SIG_ENTRIES (SIG_ENTRIES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (item),
		.lr_we   (lr_we),
		.lr_data (lr_data),
		.cmd     (cmd),
		.elem    (elem),
		.status  (status),
		.result  (result)
	);

endmodule
